// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
// clock and reset are taken from the scope that uses the macro (i_clk, i_rst_n)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// property checked on every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/dsdi_pkg.sv =====
// shared types and constants of the daily schedule dimmer interpolator
// no dependencies
package dsdi_pkg;

    localparam int LEVEL_W   = 8;
    localparam int SLOT_W    = 5;
    localparam int CHAN_W    = 3;
    localparam int MINUTE_W  = 6;
    localparam int MAX_LANES = 8;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [SLOT_W-1:0]   slot;
        logic [CHAN_W-1:0]   channel;
        logic [LEVEL_W-1:0]  level;
        logic [MINUTE_W-1:0] minute;
    } t_in_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] duty_ch0;
        logic [LEVEL_W-1:0] duty_ch1;
        logic [LEVEL_W-1:0] duty_ch2;
        logic [LEVEL_W-1:0] duty_ch3;
        logic [LEVEL_W-1:0] duty_ch4;
        logic [LEVEL_W-1:0] duty_ch5;
        logic [LEVEL_W-1:0] duty_ch6;
        logic [LEVEL_W-1:0] duty_ch7;
    } t_out_item;

    // per-cycle control from the pipeline sequencer to every channel lane
    typedef struct packed {
        logic wr_en;   // setpoint write to a slot in range
        logic ld1;     // table read stage loads
        logic ld2;     // product stage loads
        logic ld3;     // result stage loads
        logic zero2;   // item in read stage queried a slot out of range
    } t_lane_ctl;

endpackage

// ===== hw/rtl/dsdi_lane.sv =====
// one channel lane: setpoint column memory, product stage and scaled divide
// depends on dsdi_pkg
module dsdi_lane
    import dsdi_pkg::*;
#(
    parameter int NUM_SLOTS      = 24,
    parameter int STEPS_PER_SLOT = 60,
    parameter int LANE_IDX       = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_lane_ctl                         i_ctl,
    input  logic [$clog2(NUM_SLOTS)-1:0]      i_wr_slot,
    input  logic [CHAN_W-1:0]                 i_wr_chan,
    input  logic [LEVEL_W-1:0]                i_wr_level,
    input  logic [$clog2(NUM_SLOTS)-1:0]      i_rd_slot,
    input  logic [$clog2(NUM_SLOTS)-1:0]      i_rd_next,
    input  logic [$clog2(STEPS_PER_SLOT)-1:0] i_minute,
    output logic [LEVEL_W-1:0]                o_duty
);

    localparam int MW   = $clog2(STEPS_PER_SLOT);
    localparam int DIV  = STEPS_PER_SLOT - 1;
    localparam int PW   = MW + LEVEL_W;
    localparam int XW   = PW + 1;
    // shift chosen so that the reciprocal error times the largest dividend stays below 2^SH
    localparam int SH   = 2 * MW + LEVEL_W + 1;
    localparam int RW   = SH + 1;
    localparam longint RECIP_L = ((longint'(1) << SH) + longint'(DIV) - 1) / longint'(DIV);
    localparam logic [RW-1:0] RECIP  = RW'(RECIP_L);
    localparam logic [XW-1:0] BIAS   = XW'(DIV - 1);

    logic [LEVEL_W-1:0] r_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_vld;

    logic [LEVEL_W-1:0] r_a, r_b;
    logic               r_va, r_vb;
    logic [PW-1:0]      r_prod;
    logic               r_neg;
    logic [LEVEL_W-1:0] r_a2;
    logic [LEVEL_W-1:0] r_duty;

    logic               wr_hit;
    logic [LEVEL_W-1:0] a_eff, b_eff, diff;
    logic               neg;
    logic [PW-1:0]      n_prod;
    logic [XW-1:0]      dividend;
    logic [XW+RW-1:0]   scaled;
    logic [LEVEL_W-1:0] quot;
    logic [LEVEL_W-1:0] n_duty;

    assign wr_hit = i_ctl.wr_en && (i_wr_chan == CHAN_W'(LANE_IDX));

    // column memory, one write and two reads per cycle
    always_ff @(posedge i_clk) begin
        if (wr_hit) begin
            r_mem[i_wr_slot] <= i_wr_level;
        end
        if (i_ctl.ld1) begin
            r_a  <= r_mem[i_rd_slot];
            r_b  <= r_mem[i_rd_next];
            r_va <= r_vld[i_rd_slot];
            r_vb <= r_vld[i_rd_next];
        end
    end

    // an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_hit) begin
            r_vld[i_wr_slot] <= 1'b1;
        end
    end

    always_comb begin
        a_eff  = (r_va && !i_ctl.zero2) ? r_a : '0;
        b_eff  = (r_vb && !i_ctl.zero2) ? r_b : '0;
        neg    = b_eff < a_eff;
        diff   = neg ? (a_eff - b_eff) : (b_eff - a_eff);
        n_prod = PW'(i_minute) * PW'(diff);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r_prod <= n_prod;
            r_neg  <= neg;
            r_a2   <= a_eff;
        end
    end

    // floor for rising ramps, ceiling (biased dividend) for falling ones
    always_comb begin
        dividend = XW'(r_prod) + (r_neg ? BIAS : '0);
        scaled   = (XW+RW)'(dividend) * (XW+RW)'(RECIP);
        quot     = scaled[SH +: LEVEL_W];
        n_duty   = r_neg ? (r_a2 - quot) : (r_a2 + quot);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld3) begin
            r_duty <= n_duty;
        end
    end

    assign o_duty = r_duty;

endmodule

// ===== hw/rtl/daily_schedule_dimmer_interpolator.sv =====
// pipeline: a query beat passes the table read, product and divide stages before it leaves
// throughput: one beat per cycle when not stalled; setpoint writes land in the table at
// the accept edge and give no result, so a query taken in the next cycle already sees them
// stalls: each stage loads whenever it is empty or its successor moves on
// reset: synchronous active-low i_rst_n empties the pipeline and marks every table entry
// unwritten, so the whole table reads as zero at once with no clearing pass
module daily_schedule_dimmer_interpolator
    import dsdi_pkg::*;
#(
    parameter int NUM_SLOTS      = 24,
    parameter int NUM_CHANNELS   = 8,
    parameter int STEPS_PER_SLOT = 60
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int SW  = $clog2(NUM_SLOTS);
    localparam int MW  = $clog2(STEPS_PER_SLOT);
    localparam int DIV = STEPS_PER_SLOT - 1;
    localparam int SXW = (SW > SLOT_W) ? SW : SLOT_W;

    // stage occupancy
    logic r_v1, r_v2, r_v3;
    // read stage payload shared by all lanes
    logic [MW-1:0] r_m1;
    logic          r_oor1;

    logic          rdy1, rdy2, rdy3;
    logic          accept;
    logic          ld1;
    logic          slot_ok;
    logic [SXW-1:0] slot_x;
    logic [SW-1:0] slot_idx, next_idx;
    logic [MW-1:0] min_sat;
    t_lane_ctl     ctl;
    logic [LEVEL_W-1:0] duty [MAX_LANES];

    // ready ripples back from the result register
    assign rdy3 = !r_v3 || i_out_ready;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign o_in_ready = rdy1;
    assign accept     = i_in_valid && rdy1;
    assign ld1        = accept && (i_in_data.kind == KIND_QUERY);

    // slot decode: index, wrap to slot zero after the last one, range check
    always_comb begin
        slot_x   = SXW'(i_in_data.slot);
        slot_idx = slot_x[SW-1:0];
        slot_ok  = int'(i_in_data.slot) < NUM_SLOTS;
        next_idx = (slot_idx == SW'(NUM_SLOTS - 1)) ? '0 : SW'(slot_idx + 1'b1);
        // minutes past the slot pin to its last step
        min_sat  = (int'(i_in_data.minute) > DIV) ? MW'(DIV) : MW'(i_in_data.minute);
    end

    always_comb begin
        ctl.wr_en = accept && (i_in_data.kind == KIND_WRITE) && slot_ok;
        ctl.ld1   = ld1;
        ctl.ld2   = r_v1 && rdy2;
        ctl.ld3   = r_v2 && rdy3;
        ctl.zero2 = r_oor1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= ld1;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_m1   <= min_sat;
            r_oor1 <= !slot_ok;
        end
    end

    // one lane per channel; fields without a channel read zero
    for (genvar j = 0; j < MAX_LANES; j++) begin : g_lane
        if (j < NUM_CHANNELS) begin : g_on
            dsdi_lane #(
                .NUM_SLOTS      (NUM_SLOTS),
                .STEPS_PER_SLOT (STEPS_PER_SLOT),
                .LANE_IDX       (j)
            ) u_lane (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (ctl),
                .i_wr_slot  (slot_idx),
                .i_wr_chan  (i_in_data.channel),
                .i_wr_level (i_in_data.level),
                .i_rd_slot  (slot_idx),
                .i_rd_next  (next_idx),
                .i_minute   (r_m1),
                .o_duty     (duty[j])
            );
        end else begin : g_off
            assign duty[j] = '0;
        end
    end

    assign o_out_valid         = r_v3;
    assign o_out_data.duty_ch0 = duty[0];
    assign o_out_data.duty_ch1 = duty[1];
    assign o_out_data.duty_ch2 = duty[2];
    assign o_out_data.duty_ch3 = duty[3];
    assign o_out_data.duty_ch4 = duty[4];
    assign o_out_data.duty_ch5 = duty[5];
    assign o_out_data.duty_ch6 = duty[6];
    assign o_out_data.duty_ch7 = duty[7];

endmodule

// ===== hw/rtl/dsdi_checker.sv =====
// port-level checks of the daily schedule dimmer interpolator, bound to the top level
// depends on dsdi_pkg and assert_macros.svh
`include "assert_macros.svh"

module dsdi_checker
    import dsdi_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // a stalled result beat stays up
    `ASSERT_CLK(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid, "result beat dropped")
    // and keeps its payload
    `ASSERT_CLK(a_out_stable, o_out_valid && !i_out_ready |=> $stable(o_out_data), "result changed")
    // a waiting input beat stays up with its payload
    `ASSERT_CLK(a_in_hold, i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data), "input beat withdrawn")
    // with no result pending the pipeline always has room
    `ASSERT_CLK(a_ready_when_empty, !o_out_valid |-> o_in_ready, "input stalled while empty")
    // reset empties the result register
    `ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "result after reset")

endmodule

bind daily_schedule_dimmer_interpolator dsdi_checker u_dsdi_checker (.*);
